/* sv/range_sample_logger_unit_assert.svh */
// Assertion macros for the range sample logger.
// Used by range_sample_logger_unit.sv; expects clk and rst_n in scope.
`ifndef RANGE_SAMPLE_LOGGER_UNIT_ASSERT_SVH
`define RANGE_SAMPLE_LOGGER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSL_ASSERT_NOW(lbl, ante, cons, msg)
`define RSL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/rsl_pkg.sv */
// Shared constants, types and index helpers of the range sample logger.
// Depends on nothing; used by the channel interfaces and the top level.
package rsl_pkg;

  localparam int LOG_DEPTH  = 10;
  localparam int IDX_W      = $clog2(LOG_DEPTH);
  localparam int DIST_W     = 15;
  localparam int ECHO_W     = 20;
  localparam int CMD_W      = 2;
  localparam int MS_W       = 17;
  localparam int INTERVAL_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int SOUND_NUM  = 17;
  localparam int CM_DIVISOR = 1000;
  localparam int MS_PER_S   = 1000;

  // floor(echo * 17 / 1000) equals (echo * CM_RECIP) >> CM_SHIFT for every 20-bit echo.
  localparam int CM_RECIP   = 18253612;
  localparam int CM_SHIFT   = 30;
  localparam int RECIP_W    = 25;
  localparam int MUL_W      = ECHO_W + RECIP_W;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = INTERVAL_W'(1);
  localparam logic [DIST_W-1:0]     THRESHOLD_RST = DIST_W'(100);
  localparam logic [MS_W-1:0]       MS_MAX        = {MS_W{1'b1}};

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [DIST_W-1:0]    dist_t;

  localparam cmd_t CMD_TICK  = cmd_t'(0);
  localparam cmd_t CMD_POLL  = cmd_t'(1);
  localparam cmd_t CMD_DUMP  = cmd_t'(2);
  localparam cmd_t CMD_CLEAR = cmd_t'(3);

  localparam cfg_idx_t REG_INTERVAL  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_THRESHOLD = cfg_idx_t'(1);

  localparam idx_t LAST_IDX = idx_t'(LOG_DEPTH - 1);

  function automatic idx_t next_idx(input idx_t idx);
    return (idx == LAST_IDX) ? '0 : idx_t'(idx + idx_t'(1));
  endfunction

  function automatic idx_t prev_idx(input idx_t idx);
    return (idx == '0) ? LAST_IDX : idx_t'(idx - idx_t'(1));
  endfunction

endpackage

/* sv/rsl_in_if.sv */
// Input channel of the range sample logger: one command word per handshake.
// Depends on rsl_pkg.
interface rsl_in_if;
  logic                            valid;
  logic                            ready;
  rsl_pkg::cmd_t                   command;
  logic [rsl_pkg::ECHO_W-1:0]      echo_width_us;

  modport source(output valid, command, echo_width_us, input ready);
  modport sink(input valid, command, echo_width_us, output ready);
endinterface

/* sv/rsl_out_if.sv */
// Result channel of the range sample logger: one result word per handshake.
// Depends on rsl_pkg.
interface rsl_out_if;
  logic          valid;
  logic          ready;
  rsl_pkg::dist_t distance_cm;
  logic          sample_taken;
  logic          alert;
  logic          last;

  modport source(output valid, distance_cm, sample_taken, alert, last, input ready);
  modport sink(input valid, distance_cm, sample_taken, alert, last, output ready);
endinterface

/* sv/rsl_cfg_if.sv */
// Configuration write channel of the range sample logger.
// Depends on rsl_pkg.
interface rsl_cfg_if;
  logic                           valid;
  logic                           ready;
  rsl_pkg::cfg_idx_t              index;
  logic [rsl_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/range_sample_logger_unit.sv */
// Top level of the range sample logger: sequencer, shared reciprocal multiplier, log ring.
// Depends on rsl_pkg, the three channel interfaces and the assertion header.
//
// Channel  Dir  Words
// in_ch    in   command, echo_width_us
// out_ch   out  distance_cm, sample_taken, alert, last
// cfg_ch   in   index, data (always ready)
//
// A tick, clear or skipped poll passes through ST_RESP to the output register.
// A stored poll passes through ST_DIV, for the reciprocal multiply by 17/1000, then ST_RESP.
// A dump alternates ST_DUMP_RD and ST_DUMP_OUT, one log read and one result per entry.
// Input ready is low while an item is in work; a stalled result holds the sequencer.
// Reset is synchronous; log entries read as zero through per-entry valid bits.
`include "range_sample_logger_unit_assert.svh"

module range_sample_logger_unit (
  input logic         clk,
  input logic         rst_n,
  rsl_in_if.sink      in_ch,
  rsl_out_if.source   out_ch,
  rsl_cfg_if.sink     cfg_ch
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV      = 3'd1;
  localparam logic [2:0] ST_RESP     = 3'd2;
  localparam logic [2:0] ST_DUMP_RD  = 3'd3;
  localparam logic [2:0] ST_DUMP_OUT = 3'd4;

  logic [2:0]                       state_r, state_nxt;
  logic [rsl_pkg::INTERVAL_W-1:0]   interval_r;
  rsl_pkg::dist_t                   thr_r;
  rsl_pkg::idx_t                    wi_r;
  rsl_pkg::idx_t                    rd_ptr_r;
  rsl_pkg::idx_t                    dump_cnt_r;
  logic [rsl_pkg::MS_W-1:0]         elapsed_r;
  logic [rsl_pkg::LOG_DEPTH-1:0]    valid_r;
  rsl_pkg::dist_t                   latest_r;
  logic                             taken_r;
  logic [rsl_pkg::ECHO_W-1:0]       echo_r;
  rsl_pkg::dist_t                   mem [rsl_pkg::LOG_DEPTH];
  rsl_pkg::dist_t                   rd_data_r;
  logic                             rd_vld_r;
  logic                             out_valid_r;
  rsl_pkg::dist_t                   out_dist_r;
  logic                             out_taken_r;
  logic                             out_alert_r;
  logic                             out_last_r;

  logic                             accept;
  logic                             out_free;
  logic                             sample_due;
  logic                             alert;
  logic [rsl_pkg::MS_W-1:0]         interval_ms;
  logic [rsl_pkg::MUL_W-1:0]        mul;
  rsl_pkg::dist_t                   cm;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign interval_ms = rsl_pkg::MS_W'(interval_r) * rsl_pkg::MS_W'(rsl_pkg::MS_PER_S);
  assign sample_due  = elapsed_r > interval_ms;
  assign alert       = latest_r > thr_r;

  assign mul = rsl_pkg::MUL_W'(echo_r) * rsl_pkg::MUL_W'(rsl_pkg::CM_RECIP);
  assign cm  = mul[rsl_pkg::CM_SHIFT +: rsl_pkg::DIST_W];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.command == rsl_pkg::CMD_DUMP) begin
            state_nxt = ST_DUMP_RD;
          end else if (in_ch.command == rsl_pkg::CMD_POLL && sample_due) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_DIV: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        state_nxt = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (out_free) begin
          state_nxt = (dump_cnt_r == rsl_pkg::LAST_IDX) ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= rsl_pkg::INTERVAL_RST;
      thr_r      <= rsl_pkg::THRESHOLD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rsl_pkg::REG_INTERVAL:  interval_r <= cfg_ch.data[rsl_pkg::INTERVAL_W-1:0];
        rsl_pkg::REG_THRESHOLD: thr_r      <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wi_r        <= '0;
      rd_ptr_r    <= '0;
      dump_cnt_r  <= '0;
      elapsed_r   <= '0;
      valid_r     <= '0;
      latest_r    <= '0;
      taken_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            taken_r <= 1'b0;
            case (in_ch.command)
              rsl_pkg::CMD_TICK: begin
                if (elapsed_r != rsl_pkg::MS_MAX) begin
                  elapsed_r <= elapsed_r + rsl_pkg::MS_W'(1);
                end
              end
              rsl_pkg::CMD_POLL: begin
              end
              rsl_pkg::CMD_DUMP: begin
                rd_ptr_r   <= rsl_pkg::prev_idx(wi_r);
                dump_cnt_r <= '0;
              end
              default: begin
                valid_r  <= '0;
                latest_r <= '0;
              end
            endcase
          end
        end
        ST_DIV: begin
          valid_r[wi_r] <= 1'b1;
          latest_r      <= cm;
          wi_r          <= rsl_pkg::next_idx(wi_r);
          elapsed_r     <= '0;
          taken_r       <= 1'b1;
        end
        ST_RESP: begin
        end
        ST_DUMP_RD: begin
        end
        ST_DUMP_OUT: begin
          if (out_free) begin
            dump_cnt_r  <= dump_cnt_r + rsl_pkg::IDX_W'(1);
            rd_ptr_r    <= rsl_pkg::prev_idx(rd_ptr_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RESP || state_r == ST_DUMP_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.command == rsl_pkg::CMD_POLL) begin
      echo_r <= in_ch.echo_width_us;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      mem[wi_r] <= cm;
    end
    if (state_r == ST_DUMP_RD) begin
      rd_data_r <= mem[rd_ptr_r];
      rd_vld_r  <= valid_r[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP && out_free) begin
      out_dist_r  <= latest_r;
      out_taken_r <= taken_r;
      out_alert_r <= alert;
      out_last_r  <= 1'b1;
    end else if (state_r == ST_DUMP_OUT && out_free) begin
      out_dist_r  <= rd_vld_r ? rd_data_r : '0;
      out_taken_r <= 1'b0;
      out_alert_r <= alert;
      out_last_r  <= (dump_cnt_r == rsl_pkg::LAST_IDX);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.distance_cm  = out_dist_r;
  assign out_ch.sample_taken = out_taken_r;
  assign out_ch.alert        = out_alert_r;
  assign out_ch.last         = out_last_r;

  `RSL_ASSERT_NOW(a_wi_range, 1'b1, wi_r <= rsl_pkg::LAST_IDX, "write index out of range")
  `RSL_ASSERT_NEXT(a_div_store, state_r == ST_DIV,
                   state_r == ST_RESP && taken_r && elapsed_r == '0, "poll store incomplete")
  `RSL_ASSERT_NEXT(a_clear, accept && in_ch.command == rsl_pkg::CMD_CLEAR,
                   valid_r == '0 && latest_r == '0, "clear left entries valid")
  `RSL_ASSERT_NEXT(a_dump_last,
                   state_r == ST_DUMP_OUT && out_free && dump_cnt_r != rsl_pkg::LAST_IDX,
                   out_valid_r && !out_last_r, "dump marked last too early")

endmodule

/* verif/range_sample_logger_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of range_sample_logger_unit: command words go in, and each result
// word is checked against a prediction from a shadow copy of the ring, index and ms counter.
// Depends on rsl_pkg, the rsl_in_if, rsl_out_if and rsl_cfg_if interfaces and the top level.
module range_sample_logger_unit_tb;

  typedef logic [rsl_pkg::ECHO_W-1:0] echo_t;

  typedef struct packed {
    rsl_pkg::cmd_t command;
    echo_t         echo_width_us;
  } cmd_word_t;

  typedef struct packed {
    rsl_pkg::dist_t distance_cm;
    logic           sample_taken;
    logic           alert;
    logic           last;
  } result_word_t;

  logic clk;
  logic rst_n;

  rsl_in_if  in_ch();
  rsl_out_if out_ch();
  rsl_cfg_if cfg_ch();

  range_sample_logger_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cmd_word_t    pending_words[$];
  result_word_t expected_results[$];

  logic [rsl_pkg::INTERVAL_W-1:0] interval_s;
  rsl_pkg::dist_t                 threshold_cm;
  rsl_pkg::dist_t                 ring[rsl_pkg::LOG_DEPTH];
  int                             wr_pos;
  logic [rsl_pkg::MS_W-1:0]       elapsed_ms;

  bit           idle_off;
  int           gap_left;
  int           stall_left;
  int           hold_request;
  int           error_count;
  int           words_accepted;
  int           results_checked;
  int           samples_stored;
  int           dumps_seen;
  cmd_word_t    drive_word;
  result_word_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d result words still expected", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int draw_idle();
    return idle_off ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic rsl_pkg::dist_t latest_distance();
    return ring[(wr_pos + rsl_pkg::LOG_DEPTH - 1) % rsl_pkg::LOG_DEPTH];
  endfunction

  function automatic void queue_result(rsl_pkg::dist_t distance, logic taken, logic last);
    result_word_t r;
    r.distance_cm  = distance;
    r.sample_taken = taken;
    r.alert        = latest_distance() > threshold_cm;
    r.last         = last;
    expected_results.push_back(r);
  endfunction

  function automatic void log_command(rsl_pkg::cmd_t command, echo_t echo);
    logic taken;
    int   cm;
    taken = 1'b0;
    if (command == rsl_pkg::CMD_TICK) begin
      if (elapsed_ms != rsl_pkg::MS_MAX) elapsed_ms++;
    end else if (command == rsl_pkg::CMD_POLL) begin
      if (int'(elapsed_ms) > int'(interval_s) * rsl_pkg::MS_PER_S) begin
        cm = int'(echo) * rsl_pkg::SOUND_NUM / rsl_pkg::CM_DIVISOR;
        ring[wr_pos] = rsl_pkg::dist_t'(cm);
        wr_pos = (wr_pos + 1) % rsl_pkg::LOG_DEPTH;
        elapsed_ms = '0;
        taken = 1'b1;
        samples_stored++;
      end
    end else if (command == rsl_pkg::CMD_DUMP) begin
      for (int i = 1; i <= rsl_pkg::LOG_DEPTH; i++) begin
        queue_result(ring[(rsl_pkg::LOG_DEPTH - i + wr_pos) % rsl_pkg::LOG_DEPTH], 1'b0,
                     i == rsl_pkg::LOG_DEPTH);
      end
      dumps_seen++;
      return;
    end else begin
      foreach (ring[i]) ring[i] = '0;
    end
    queue_result(latest_distance(), taken, 1'b1);
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("MISMATCH at result word %0d: %s", results_checked, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        words_accepted++;
        log_command(in_ch.command, in_ch.echo_width_us);
        gap_left = draw_idle();
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left == 0 && pending_words.size() != 0) begin
          drive_word = pending_words.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.command       <= drive_word.command;
          in_ch.echo_width_us <= drive_word.echo_width_us;
        end else begin
          if (gap_left != 0) gap_left--;
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word, distance_cm %0d", out_ch.distance_cm));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.distance_cm !== want.distance_cm)
            report_mismatch($sformatf("distance_cm got %0d expected %0d",
                                      out_ch.distance_cm, want.distance_cm));
          if (out_ch.sample_taken !== want.sample_taken)
            report_mismatch($sformatf("sample_taken got %b expected %b",
                                      out_ch.sample_taken, want.sample_taken));
          if (out_ch.alert !== want.alert)
            report_mismatch($sformatf("alert got %b expected %b", out_ch.alert, want.alert));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last got %b expected %b", out_ch.last, want.last));
        end
        stall_left = draw_idle();
      end
      if (hold_request != 0) begin
        hold_request--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_word(rsl_pkg::cmd_t command, echo_t echo);
    cmd_word_t w;
    w.command       = command;
    w.echo_width_us = echo;
    pending_words.push_back(w);
  endtask

  task automatic push_ticks(int count);
    repeat (count) push_word(rsl_pkg::CMD_TICK, echo_t'($urandom));
  endtask

  function automatic echo_t random_echo();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return echo_t'($urandom_range(0, 200));
    return echo_t'($urandom_range(0, 20'hFFFFF));
  endfunction

  // Mostly tick-then-poll pairs so samples land, with lone polls, ticks, dumps and clears.
  task automatic push_random_words(int count);
    int n;
    int pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_word(rsl_pkg::CMD_TICK, random_echo());
        push_word(rsl_pkg::CMD_POLL, random_echo());
        n += 2;
      end else begin
        if (pick < 58) push_word(rsl_pkg::CMD_POLL, random_echo());
        else if (pick < 72) push_word(rsl_pkg::CMD_TICK, random_echo());
        else if (pick < 86) push_word(rsl_pkg::CMD_DUMP, random_echo());
        else push_word(rsl_pkg::CMD_CLEAR, random_echo());
        n++;
      end
    end
  endtask

  task automatic write_reg(rsl_pkg::cfg_idx_t reg_index,
                           logic [rsl_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= reg_index;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (reg_index == rsl_pkg::REG_INTERVAL) interval_s = value[rsl_pkg::INTERVAL_W-1:0];
    else if (reg_index == rsl_pkg::REG_THRESHOLD) threshold_cm = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = rsl_pkg::CMD_TICK;
    in_ch.echo_width_us = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = rsl_pkg::REG_INTERVAL;
    cfg_ch.data         = '0;
    interval_s          = rsl_pkg::INTERVAL_RST;
    threshold_cm        = rsl_pkg::THRESHOLD_RST;
    foreach (ring[i]) ring[i] = '0;
    wr_pos              = 0;
    elapsed_ms          = '0;
    idle_off            = 1'b0;
    hold_request        = 0;
    error_count         = 0;
    words_accepted      = 0;
    results_checked     = 0;
    samples_stored      = 0;
    dumps_seen          = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: an early poll is refused and the log reads back as zeros.
    push_word(rsl_pkg::CMD_POLL, 20'd50000);
    push_word(rsl_pkg::CMD_DUMP, '0);
    wait_drained();

    write_reg(rsl_pkg::REG_INTERVAL, 15'd0);
    write_reg(rsl_pkg::REG_THRESHOLD, 15'd100);
    write_reg(rsl_pkg::cfg_idx_t'(2), 15'h7FFF);
    write_reg(rsl_pkg::cfg_idx_t'(3), 15'h5555);
    push_word(rsl_pkg::CMD_POLL, 20'd3000);
    push_word(rsl_pkg::CMD_TICK, '0);
    push_word(rsl_pkg::CMD_POLL, '0);
    push_word(rsl_pkg::CMD_TICK, '1);
    push_word(rsl_pkg::CMD_POLL, '1);
    push_word(rsl_pkg::CMD_TICK, '0);
    push_word(rsl_pkg::CMD_POLL, 20'd1000000);
    push_word(rsl_pkg::CMD_TICK, '0);
    push_word(rsl_pkg::CMD_POLL, 20'd5941);
    push_word(rsl_pkg::CMD_TICK, '0);
    push_word(rsl_pkg::CMD_POLL, 20'd5942);
    push_word(rsl_pkg::CMD_POLL, 20'd5000);
    push_word(rsl_pkg::CMD_TICK, '0);
    push_word(rsl_pkg::CMD_TICK, '0);
    push_word(rsl_pkg::CMD_POLL, 20'd58);
    push_word(rsl_pkg::CMD_CLEAR, '1);
    push_word(rsl_pkg::CMD_DUMP, '0);
    push_word(rsl_pkg::CMD_TICK, '0);
    push_word(rsl_pkg::CMD_POLL, 20'd1234);
    push_word(rsl_pkg::CMD_DUMP, '1);
    wait_drained();

    // Largest interval, written with all data bits set: a poll after a few ticks is refused.
    write_reg(rsl_pkg::REG_INTERVAL, 15'h7FFF);
    write_reg(rsl_pkg::REG_THRESHOLD, 15'd17000);
    push_ticks(3);
    push_word(rsl_pkg::CMD_POLL, 20'd999999);
    push_word(rsl_pkg::CMD_DUMP, '0);
    wait_drained();

    write_reg(rsl_pkg::REG_INTERVAL, 15'd0);
    write_reg(rsl_pkg::REG_THRESHOLD, 15'h7FFF);
    write_reg(rsl_pkg::cfg_idx_t'(2), rsl_pkg::CFG_DATA_W'($urandom));
    push_random_words(100);
    wait_drained();

    // The receiver holds off for a long stretch while words keep coming.
    idle_off = 1'b1;
    write_reg(rsl_pkg::REG_THRESHOLD, 15'd0);
    write_reg(rsl_pkg::cfg_idx_t'(3), rsl_pkg::CFG_DATA_W'($urandom));
    @(negedge clk);
    hold_request = 400;
    push_random_words(100);
    wait_drained();

    idle_off = 1'b0;
    write_reg(rsl_pkg::REG_THRESHOLD, rsl_pkg::dist_t'($urandom_range(0, 17825)));
    push_random_words(60);
    wait_drained();
    push_random_words(50);
    wait_drained();

    write_reg(rsl_pkg::REG_INTERVAL,
              {(rsl_pkg::CFG_DATA_W - rsl_pkg::INTERVAL_W)'($urandom),
               rsl_pkg::INTERVAL_W'(0)});
    write_reg(rsl_pkg::REG_THRESHOLD, rsl_pkg::dist_t'($urandom_range(0, 17825)));
    push_random_words(80);
    wait_drained();
    repeat (30) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_results.size()));
    $display("Run covered %0d command words and %0d result words, %0d stored samples, %0d dumps,",
             words_accepted, results_checked, samples_stored, dumps_seen);
    $display("intervals 0, 1 and 63 s, thresholds 0 to 32767 and a long receiver stall.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/rsl_pkg.sv
sv/rsl_in_if.sv
sv/rsl_out_if.sv
sv/rsl_cfg_if.sv
sv/range_sample_logger_unit.sv
verif/range_sample_logger_unit_tb.sv
